/* rtl/core/tod_pkg.sv */
package tod_pkg;

  // Time base
  localparam int unsigned SecPerDay  = 86400;
  localparam int unsigned SecPerHour = 3600;
  localparam int unsigned SecPerMin  = 60;

  localparam logic [4:0] HoursPerDay = 5'd24;
  localparam logic [4:0] MaxHour     = 5'd23;
  localparam logic [5:0] MaxMinSec   = 6'd59;
  localparam logic [5:0] MinSecWrap  = 6'd60;

  // Field widths
  localparam int unsigned ReqW    = 3;
  localparam int unsigned FieldW  = 16;
  localparam int unsigned OffsetW = 32;
  localparam int unsigned GivenW  = 28;
  localparam int unsigned TotalW  = 17;
  localparam int unsigned DiffW   = 28;

  // Floor modulo 86400 of a biased 32-bit word: 86400 = 128 * 675
  localparam logic [9:0]  ModBase   = 10'd675;
  localparam logic [24:0] Recip675  = 25'd25451658;   // floor(2^34 / 675)
  localparam int unsigned Recip675Sh = 34;
  // 2^31 mod 86400, removed again after the bias
  localparam logic [16:0] BiasModDay   = 17'd11648;
  localparam logic [16:0] DayMinusBias = 17'(SecPerDay - 11648);
  localparam logic [16:0] DayTotal     = 17'(SecPerDay);

  // Exact reciprocals for values below 86400
  localparam logic [18:0] Recip3600   = 19'd298262;   // ceil(2^30 / 3600)
  localparam int unsigned Recip3600Sh = 30;
  localparam logic [18:0] Recip60     = 19'd279621;   // ceil(2^24 / 60)
  localparam int unsigned Recip60Sh   = 24;

  typedef enum logic [ReqW-1:0] {
    REQ_SET_CHECKED = 3'd0,
    REQ_SET_NORM    = 3'd1,
    REQ_TICK_FWD    = 3'd2,
    REQ_TICK_BACK   = 3'd3,
    REQ_SHIFT       = 3'd4,
    REQ_DIFF        = 3'd5
  } tod_req_e;

  typedef struct packed {
    logic [4:0] hr;
    logic [5:0] mn;
    logic [5:0] sc;
  } tod_hms_t;

  // Raw request as taken from the slave side
  typedef struct packed {
    logic signed [OffsetW-1:0] offset;
    logic signed [FieldW-1:0]  sc;
    logic signed [FieldW-1:0]  mn;
    logic signed [FieldW-1:0]  hr;
    logic [ReqW-1:0]           req;
  } tod_in_t;

  // Request fields carried down the pipeline
  typedef struct packed {
    tod_req_e                 req;
    logic                     bad;
    tod_hms_t                 set_hms;
    logic signed [GivenW-1:0] given;
  } tod_cmd_t;

endpackage

/* rtl/core/tod_skid.sv */
module tod_skid import tod_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  tod_in_t in_data_i,
  input  logic    adv_i,
  output logic    out_valid_o,
  output tod_in_t out_data_o
);

  logic    skid_valid_q;
  tod_in_t skid_q;

  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = skid_valid_q | in_valid_i;
  assign out_data_o  = skid_valid_q ? skid_q : in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (adv_i) begin
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Park a transfer that arrives while the pipeline is held
  always_ff @(posedge clk_i) begin
    if (!adv_i && in_valid_i && !skid_valid_q) begin
      skid_q <= in_data_i;
    end
  end

endmodule

/* rtl/core/tod_front.sv */
module tod_front import tod_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  tod_in_t                   data_i,
  output logic                      valid_o,
  output tod_cmd_t                  cmd_o,
  output logic signed [OffsetW-1:0] offset_o
);

  logic signed [GivenW-1:0] given_c;
  logic                     bad_c;
  tod_cmd_t                 cmd_q;
  logic signed [OffsetW-1:0] offset_q;
  logic                     valid_q;

  // Given time in seconds, taken as is
  assign given_c = (GivenW'(data_i.hr) * GivenW'(signed'(SecPerHour)))
                 + (GivenW'(data_i.mn) * GivenW'(signed'(SecPerMin)))
                 + GivenW'(data_i.sc);

  assign bad_c = (data_i.hr < 0) || (data_i.hr > signed'(FieldW'(MaxHour)))
              || (data_i.mn < 0) || (data_i.mn > signed'(FieldW'(MaxMinSec)))
              || (data_i.sc < 0) || (data_i.sc > signed'(FieldW'(MaxMinSec)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cmd_q.req        <= tod_req_e'(data_i.req);
      cmd_q.bad        <= bad_c;
      cmd_q.set_hms.hr <= data_i.hr[4:0];
      cmd_q.set_hms.mn <= data_i.mn[5:0];
      cmd_q.set_hms.sc <= data_i.sc[5:0];
      cmd_q.given      <= given_c;
      offset_q         <= data_i.offset;
    end
  end

  assign valid_o  = valid_q;
  assign cmd_o    = cmd_q;
  assign offset_o = offset_q;

endmodule

/* rtl/core/tod_mod_day.sv */
module tod_mod_day import tod_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  tod_cmd_t                  cmd_i,
  input  logic signed [OffsetW-1:0] offset_i,
  output logic                      valid_o,
  output tod_cmd_t                  cmd_o,
  output logic [TotalW-1:0]         total_o,
  output tod_hms_t                  hms_o
);

  logic [4:0]     valid_q;
  tod_cmd_t       cmd_b_q, cmd_c_q, cmd_d_q, cmd_e_q, cmd_f_q;

  logic signed [OffsetW-1:0] v_c;
  logic [OffsetW-1:0]        u_c;
  logic [49:0]               prod_c;
  logic [24:0]               x_q;
  logic [6:0]                lo_q;
  logic [15:0]               q_q;

  logic [24:0]               qm_c;
  logic [10:0]               r675_c;
  logic [9:0]                r675_fix_c;
  logic [TotalW-1:0]         rr_q;

  logic [TotalW-1:0]         r_d_q;

  logic [35:0]               ph_c, pm_c;
  logic [4:0]                hr_e_q;
  logic [10:0]               q60_e_q;
  logic [TotalW-1:0]         r_e_q;

  logic [TotalW-1:0]         sc_full_c;
  logic [10:0]               mn_full_c;
  tod_hms_t                  hms_f_q;
  logic [TotalW-1:0]         r_f_q;

  // Stage B: pick the signed amount, bias it, estimate the quotient by 675
  always_comb begin
    case (cmd_i.req)
      REQ_SET_NORM:  v_c = OffsetW'(cmd_i.given);
      REQ_TICK_FWD:  v_c = OffsetW'(1);
      REQ_TICK_BACK: v_c = -OffsetW'(1);
      REQ_SHIFT:     v_c = offset_i;
      default:       v_c = '0;
    endcase
  end

  assign u_c    = {~v_c[OffsetW-1], v_c[OffsetW-2:0]};
  assign prod_c = {25'd0, u_c[31:7]} * {25'd0, Recip675};

  // Stage C: remainder by 675, one correction step
  assign qm_c       = 25'(q_q) * 25'(ModBase);
  assign r675_c     = 11'(x_q - qm_c);
  assign r675_fix_c = (r675_c >= 11'(ModBase)) ? 10'(r675_c - 11'(ModBase))
                                               : r675_c[9:0];

  // Stage E: hours and whole minutes from seconds of day
  assign ph_c = {19'd0, r_d_q} * {17'd0, Recip3600};
  assign pm_c = {19'd0, r_d_q} * {17'd0, Recip60};

  // Stage F: split off minutes and seconds
  assign sc_full_c = r_e_q - (TotalW'(q60_e_q) * TotalW'(SecPerMin));
  assign mn_full_c = q60_e_q - (11'(hr_e_q) * 11'(SecPerMin));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cmd_b_q <= cmd_i;
      x_q     <= u_c[31:7];
      lo_q    <= u_c[6:0];
      q_q     <= prod_c[49:Recip675Sh];

      cmd_c_q <= cmd_b_q;
      rr_q    <= {r675_fix_c, lo_q};

      // Remove the bias, wrap into one day
      cmd_d_q <= cmd_c_q;
      r_d_q   <= (rr_q >= BiasModDay) ? (rr_q - BiasModDay) : (rr_q + DayMinusBias);

      cmd_e_q <= cmd_d_q;
      hr_e_q  <= ph_c[Recip3600Sh+4:Recip3600Sh];
      q60_e_q <= pm_c[Recip60Sh+10:Recip60Sh];
      r_e_q   <= r_d_q;

      cmd_f_q    <= cmd_e_q;
      hms_f_q.hr <= hr_e_q;
      hms_f_q.mn <= mn_full_c[5:0];
      hms_f_q.sc <= sc_full_c[5:0];
      r_f_q      <= r_e_q;
    end
  end

  assign valid_o = valid_q[4];
  assign cmd_o   = cmd_f_q;
  assign total_o = r_f_q;
  assign hms_o   = hms_f_q;

endmodule

/* rtl/core/tod_core.sv */
module tod_core import tod_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  tod_cmd_t                 cmd_i,
  input  logic [TotalW-1:0]        total_i,
  input  tod_hms_t                 hms_i,
  output logic                     adv_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     status_o,
  output tod_hms_t                 time_o,
  output logic signed [DiffW-1:0]  diff_o
);

  tod_hms_t          time_q, time_d;
  logic [TotalW-1:0] tot_q, tot_d;
  logic              out_valid_q;
  logic              status_q, status_d;
  logic signed [DiffW-1:0] diff_q, diff_d;

  logic [6:0]        sc_sum_c, mn_sum_c;
  logic [5:0]        hr_sum_c;
  logic              c_sc, c_mn;
  tod_hms_t          add_hms_c;
  logic [TotalW:0]   tot_sum_c;
  logic [TotalW-1:0] tot_add_c;

  assign adv_o = ~out_valid_q | out_ready_i;

  // Add a time of day with carries across the three counters
  always_comb begin
    sc_sum_c     = 7'(time_q.sc) + 7'(hms_i.sc);
    c_sc         = (sc_sum_c >= 7'(MinSecWrap));
    add_hms_c.sc = c_sc ? 6'(sc_sum_c - 7'(MinSecWrap)) : sc_sum_c[5:0];
    mn_sum_c     = 7'(time_q.mn) + 7'(hms_i.mn) + 7'(c_sc);
    c_mn         = (mn_sum_c >= 7'(MinSecWrap));
    add_hms_c.mn = c_mn ? 6'(mn_sum_c - 7'(MinSecWrap)) : mn_sum_c[5:0];
    hr_sum_c     = 6'(time_q.hr) + 6'(hms_i.hr) + 6'(c_mn);
    add_hms_c.hr = (hr_sum_c >= 6'(HoursPerDay)) ? 5'(hr_sum_c - 6'(HoursPerDay))
                                                 : hr_sum_c[4:0];
    tot_sum_c    = (TotalW+1)'(tot_q) + (TotalW+1)'(total_i);
    tot_add_c    = (tot_sum_c >= (TotalW+1)'(DayTotal))
                 ? TotalW'(tot_sum_c - (TotalW+1)'(DayTotal)) : tot_sum_c[TotalW-1:0];
  end

  always_comb begin
    time_d   = time_q;
    tot_d    = tot_q;
    status_d = 1'b0;
    diff_d   = '0;
    case (cmd_i.req)
      REQ_SET_CHECKED: begin
        if (cmd_i.bad) begin
          status_d = 1'b1;
        end else begin
          time_d = cmd_i.set_hms;
          tot_d  = cmd_i.given[TotalW-1:0];
        end
      end
      REQ_SET_NORM: begin
        time_d = hms_i;
        tot_d  = total_i;
      end
      REQ_TICK_FWD, REQ_TICK_BACK, REQ_SHIFT: begin
        time_d = add_hms_c;
        tot_d  = tot_add_c;
      end
      REQ_DIFF: begin
        diff_d = signed'({(DiffW-TotalW)'(0), tot_q}) - cmd_i.given;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      time_q      <= '0;
      tot_q       <= '0;
    end else if (adv_o) begin
      out_valid_q <= valid_i;
      if (valid_i) begin
        time_q <= time_d;
        tot_q  <= tot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      status_q <= status_d;
      diff_q   <= diff_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign time_o      = time_q;
  assign diff_o      = diff_q;

endmodule

/* rtl/core/time_of_day_clock_hms.sv */
// Channel   Dir  tuser               tdata (lowest bit up)
// s_axis    in   req_type[2:0]       hours_in[15:0] minutes_in[31:16]
//                                     seconds_in[47:32] offset[79:48]
// m_axis    out  status[0]           hours[4:0] minutes[10:5] seconds[16:11]
//                                     difference[44:17], zero pad[47:45]
//
// One transfer in and one result out per cycle unless m_axis stalls; a result passes
// the front register, the day reduction stages B to F and the final stage, which
// sets the rate: it updates three time counters and a seconds-of-day total together.
// Reset clears the time to 00:00:00. A stall on m_axis holds the whole pipeline;
// one transfer is parked in the input skid so s_axis_tready is a register output.
module time_of_day_clock_hms import tod_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // hours_in, minutes_in, seconds_in, offset
  input  logic [2:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // hours, minutes, seconds, difference, pad
  output logic [0:0]  m_axis_tuser    // status
);

  tod_in_t  in_req;
  tod_in_t  skid_data;
  logic     skid_valid;
  logic     adv;

  logic                      front_valid;
  tod_cmd_t                  front_cmd;
  logic signed [OffsetW-1:0] front_offset;

  logic              mod_valid;
  tod_cmd_t          mod_cmd;
  logic [TotalW-1:0] mod_total;
  tod_hms_t          mod_hms;

  logic                    res_status;
  tod_hms_t                res_time;
  logic signed [DiffW-1:0] res_diff;

  // Unpack the request
  assign in_req.req    = s_axis_tuser;
  assign in_req.hr     = s_axis_tdata[15:0];
  assign in_req.mn     = s_axis_tdata[31:16];
  assign in_req.sc     = s_axis_tdata[47:32];
  assign in_req.offset = s_axis_tdata[79:48];

  tod_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_req),
    .adv_i       (adv),
    .out_valid_o (skid_valid),
    .out_data_o  (skid_data)
  );

  // Given time in seconds and the range check for a checked set
  tod_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (skid_valid),
    .data_i   (skid_data),
    .valid_o  (front_valid),
    .cmd_o    (front_cmd),
    .offset_o (front_offset)
  );

  // Reduce the signed amount modulo one day and split it into h:m:s
  tod_mod_day u_mod_day (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (front_valid),
    .cmd_i    (front_cmd),
    .offset_i (front_offset),
    .valid_o  (mod_valid),
    .cmd_o    (mod_cmd),
    .total_o  (mod_total),
    .hms_o    (mod_hms)
  );

  // Apply the request to the stored time and hold the result
  tod_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (mod_valid),
    .cmd_i       (mod_cmd),
    .total_i     (mod_total),
    .hms_i       (mod_hms),
    .adv_o       (adv),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (res_status),
    .time_o      (res_time),
    .diff_o      (res_diff)
  );

  assign m_axis_tuser = res_status;
  assign m_axis_tdata = {3'b000, res_diff, res_time.sc, res_time.mn, res_time.hr};

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tod_pkg::*;

  // Request codes the block leaves unused; it must treat them as no-ops
  localparam logic [ReqW-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [ReqW-1:0] REQ_RSVD7 = 3'd7;

  // Time base as signed 64-bit so the day arithmetic below stays signed
  localparam longint DAY_S  = longint'(SecPerDay);
  localparam longint HOUR_S = longint'(SecPerHour);
  localparam longint MIN_S  = longint'(SecPerMin);
  localparam int     HR_MAX = int'(MaxHour);
  localparam int     MS_MAX = int'(MaxMinSec);

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int RANDOM_PER_PHASE = 367;

  // One result as it leaves m_axis
  typedef struct packed {
    logic                     status;
    logic [4:0]               hr;
    logic [5:0]               mn;
    logic [5:0]               sc;
    logic signed [DiffW-1:0]  diff;
  } tod_out_t;

  // One request row; pinned rows carry a hand-written result
  typedef struct packed {
    logic [ReqW-1:0]            req;
    logic signed [FieldW-1:0]   hr_in;
    logic signed [FieldW-1:0]   mn_in;
    logic signed [FieldW-1:0]   sc_in;
    logic signed [OffsetW-1:0]  off_in;
    logic                       pinned;
    tod_out_t                   pin;
  } tod_req_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;   // hours_in, minutes_in, seconds_in, offset
  logic [2:0]  s_axis_tuser  = '0;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // hours, minutes, seconds, difference, pad
  logic [0:0]  m_axis_tuser;         // status

  // Row currently on s_axis, moved with the bus so the monitor sees the one
  // that belongs to the transfer at each edge
  tod_req_row_t drv_row = '0;

  // Predicted clock state
  logic [4:0] tod_hr = '0;
  logic [5:0] tod_mn = '0;
  logic [5:0] tod_sc = '0;

  tod_out_t expected_time_q[$];
  int       mismatch_count = 0;
  int       idle_cycles    = 0;
  int       src_idle       = 33;
  int       dst_idle       = 57;

  // Directed rows: reset state, midnight wrap both ways, every rejected field,
  // the field and offset extremes, a spare code and the difference extremes
  tod_req_row_t dir_tbl [0:24] = '{
    '{REQ_DIFF,        16'sd0,     16'sd0,     16'sd0,     32'sd0,
      1'b1, '{1'b0, 5'd0, 6'd0, 6'd0, 28'sd0}},
    '{REQ_TICK_BACK,   16'sd5,     16'sd5,     16'sd5,     32'sd77,
      1'b1, '{1'b0, 5'd23, 6'd59, 6'd59, 28'sd0}},
    '{REQ_TICK_FWD,    16'sd0,     16'sd0,     16'sd0,     32'sd0,
      1'b1, '{1'b0, 5'd0, 6'd0, 6'd0, 28'sd0}},
    '{REQ_SET_CHECKED, 16'sd23,    16'sd59,    16'sd59,    32'sd0,
      1'b1, '{1'b0, 5'd23, 6'd59, 6'd59, 28'sd0}},
    '{REQ_TICK_FWD,    16'sd0,     16'sd0,     16'sd0,     32'sd0,
      1'b1, '{1'b0, 5'd0, 6'd0, 6'd0, 28'sd0}},
    '{REQ_SET_CHECKED, 16'sd24,    16'sd0,     16'sd0,     32'sd0,
      1'b1, '{1'b1, 5'd0, 6'd0, 6'd0, 28'sd0}},
    '{REQ_SET_CHECKED, -16'sd1,    16'sd0,     16'sd0,     32'sd0,
      1'b1, '{1'b1, 5'd0, 6'd0, 6'd0, 28'sd0}},
    '{REQ_SET_CHECKED, 16'sd0,     16'sd60,    16'sd0,     32'sd0,
      1'b1, '{1'b1, 5'd0, 6'd0, 6'd0, 28'sd0}},
    '{REQ_SET_CHECKED, 16'sd0,     16'sd0,     16'sd60,    32'sd0,
      1'b1, '{1'b1, 5'd0, 6'd0, 6'd0, 28'sd0}},
    '{REQ_SET_CHECKED, 16'sd0,     16'sd0,     -16'sd1,    32'sd0,
      1'b1, '{1'b1, 5'd0, 6'd0, 6'd0, 28'sd0}},
    '{REQ_SET_CHECKED, 16'sh8000,  16'sh7fff,  16'sh8000,  32'sd0,
      1'b1, '{1'b1, 5'd0, 6'd0, 6'd0, 28'sd0}},
    '{REQ_SET_CHECKED, 16'sd12,    16'sd34,    16'sd56,    32'sd0,
      1'b1, '{1'b0, 5'd12, 6'd34, 6'd56, 28'sd0}},
    '{REQ_SET_NORM,    16'sd0,     16'sd0,     -16'sd1,    32'sd0,
      1'b1, '{1'b0, 5'd23, 6'd59, 6'd59, 28'sd0}},
    '{REQ_SET_NORM,    16'sd24,    16'sd0,     16'sd0,     32'sd0,
      1'b1, '{1'b0, 5'd0, 6'd0, 6'd0, 28'sd0}},
    '{REQ_SET_NORM,    16'sh8000,  16'sh8000,  16'sh8000,  32'sd0,   1'b0, '0},
    '{REQ_SET_NORM,    16'sh7fff,  16'sh7fff,  16'sh7fff,  32'sd0,   1'b0, '0},
    '{REQ_SHIFT,       16'sd0,     16'sd0,     16'sd0,  32'sh80000000, 1'b0, '0},
    '{REQ_SHIFT,       16'sd0,     16'sd0,     16'sd0,  32'sh7fffffff, 1'b0, '0},
    '{REQ_SHIFT,       16'sh7fff,  16'sh8000,  16'sd3,     32'sd86400, 1'b0, '0},
    '{REQ_RSVD6,       16'sh5a5a,  16'sha5a5,  16'sh0ff0,  32'sh12345678, 1'b0, '0},
    '{REQ_SET_CHECKED, 16'sd23,    16'sd59,    16'sd59,    32'sd0,
      1'b1, '{1'b0, 5'd23, 6'd59, 6'd59, 28'sd0}},
    '{REQ_DIFF,        16'sh8000,  16'sh8000,  16'sh8000,  32'sd0,
      1'b1, '{1'b0, 5'd23, 6'd59, 6'd59, 28'sd120050047}},
    '{REQ_SET_CHECKED, 16'sd0,     16'sd0,     16'sd0,     32'sd0,
      1'b1, '{1'b0, 5'd0, 6'd0, 6'd0, 28'sd0}},
    '{REQ_DIFF,        16'sh7fff,  16'sh7fff,  16'sh7fff,  32'sh7fffffff,
      1'b1, '{1'b0, 5'd0, 6'd0, 6'd0, -28'sd119959987}},
    '{REQ_DIFF,        16'sd0,     16'sd0,     16'sd0,  32'sh80000000,
      1'b1, '{1'b0, 5'd0, 6'd0, 6'd0, 28'sd0}}
  };

  time_of_day_clock_hms dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Reduce a signed second count onto the day (floor modulo) and load it
  function automatic void load_day_seconds(longint t);
    longint r;
    r = t % DAY_S;
    if (r < 0) r += DAY_S;
    tod_hr = 5'(r / HOUR_S);
    tod_mn = 6'((r / MIN_S) % 60);
    tod_sc = 6'(r % 60);
  endfunction

  // Apply one request to the predicted clock and return the result it yields
  function automatic tod_out_t predict_tod(logic [ReqW-1:0] req,
                                           logic signed [FieldW-1:0] h,
                                           logic signed [FieldW-1:0] m,
                                           logic signed [FieldW-1:0] s,
                                           logic signed [OffsetW-1:0] off);
    tod_out_t r;
    longint   given;
    longint   stored;
    given  = longint'(h) * HOUR_S + longint'(m) * MIN_S + longint'(s);
    stored = longint'(tod_hr) * HOUR_S + longint'(tod_mn) * MIN_S + longint'(tod_sc);
    r = '0;
    case (req)
      REQ_SET_CHECKED: begin
        // Reject the whole set if any field is off the clock face
        if (h < 0 || h > HR_MAX || m < 0 || m > MS_MAX || s < 0 || s > MS_MAX) begin
          r.status = 1'b1;
        end else begin
          tod_hr = h[4:0];
          tod_mn = m[5:0];
          tod_sc = s[5:0];
        end
      end
      REQ_SET_NORM:  load_day_seconds(given);
      REQ_TICK_FWD:  load_day_seconds(stored + 1);
      REQ_TICK_BACK: load_day_seconds(stored - 1);
      REQ_SHIFT:     load_day_seconds(stored + longint'(off));
      REQ_DIFF:      r.diff = DiffW'(stored - given);
      default: ;
    endcase
    r.hr = tod_hr;
    r.mn = tod_mn;
    r.sc = tod_sc;
    return r;
  endfunction

  // Signed value in a small window around zero
  function automatic logic signed [FieldW-1:0] near_zero(int unsigned span);
    return FieldW'(int'($urandom_range(span)) - int'(span / 2));
  endfunction

  // Mostly well-formed requests with random content, plus spare codes and
  // full-width noise in every field so each input bit toggles
  function automatic tod_req_row_t random_row();
    tod_req_row_t row;
    int unsigned  pick;
    row        = '0;
    row.hr_in  = FieldW'($urandom);
    row.mn_in  = FieldW'($urandom);
    row.sc_in  = FieldW'($urandom);
    row.off_in = $urandom;
    pick = $urandom_range(99);
    if (pick < 16) begin
      row.req = REQ_SET_CHECKED;
      if ($urandom_range(4) == 0) begin
        // Land just before midnight so the ticks that follow wrap
        row.hr_in = 16'sd23;
        row.mn_in = 16'sd59;
        row.sc_in = FieldW'($urandom_range(59, 55));
      end else begin
        if ($urandom_range(3) != 0) row.hr_in = FieldW'($urandom_range(HR_MAX));
        if ($urandom_range(3) != 0) row.mn_in = FieldW'($urandom_range(MS_MAX));
        if ($urandom_range(3) != 0) row.sc_in = FieldW'($urandom_range(MS_MAX));
      end
    end else if (pick < 30) begin
      row.req = REQ_SET_NORM;
      if ($urandom_range(1) == 0) begin
        row.hr_in = near_zero(60);
        row.mn_in = near_zero(240);
        row.sc_in = near_zero(240);
      end
    end else if (pick < 48) begin
      row.req = REQ_TICK_FWD;
    end else if (pick < 64) begin
      row.req = REQ_TICK_BACK;
    end else if (pick < 80) begin
      row.req = REQ_SHIFT;
      case ($urandom_range(2))
        0: row.off_in = OffsetW'(int'($urandom_range(200)) - 100);
        1: row.off_in = OffsetW'((int'($urandom_range(40)) - 20) * int'(DAY_S)
                                 + int'($urandom_range(4)) - 2);
        default: ;
      endcase
    end else if (pick < 96) begin
      row.req = REQ_DIFF;
      if ($urandom_range(1) == 0) begin
        row.hr_in = near_zero(50);
        row.mn_in = near_zero(130);
        row.sc_in = near_zero(130);
      end
    end else begin
      row.req = ($urandom_range(1) == 0) ? REQ_RSVD6 : REQ_RSVD7;
    end
    return row;
  endfunction

  // Present one request and hold it until the slave side takes it
  task automatic send_request(input tod_req_row_t row);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row.off_in, row.sc_in, row.mn_in, row.hr_in};
    s_axis_tuser  <= row.req;
    drv_row       <= row;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string field, input longint exp_v, input longint act_v);
    mismatch_count++;
    $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
  endtask

  // Stall the master side at random; one assignment per edge
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle);
  end

  // Predict on every accepted request, check every accepted result and
  // watch for a bus that has stopped moving
  always @(posedge clk_i) begin : monitor
    tod_out_t want;
    tod_out_t got;
    logic     moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        want = predict_tod(s_axis_tuser, $signed(s_axis_tdata[15:0]),
                           $signed(s_axis_tdata[31:16]), $signed(s_axis_tdata[47:32]),
                           $signed(s_axis_tdata[79:48]));
        // Pinned rows still advance the predicted clock above
        if (drv_row.pinned) want = drv_row.pin;
        expected_time_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got.status = m_axis_tuser[0];
        got.hr     = m_axis_tdata[4:0];
        got.mn     = m_axis_tdata[10:5];
        got.sc     = m_axis_tdata[16:11];
        got.diff   = m_axis_tdata[44:17];
        if (expected_time_q.size() == 0) begin
          mismatch_count++;
          $error("result transfer with no request outstanding");
        end else begin
          want = expected_time_q.pop_front();
          if (got.status !== want.status) flag_mismatch("status", want.status, got.status);
          if (got.hr !== want.hr) flag_mismatch("hours", want.hr, got.hr);
          if (got.mn !== want.mn) flag_mismatch("minutes", want.mn, got.mn);
          if (got.sc !== want.sc) flag_mismatch("seconds", want.sc, got.sc);
          if (got.diff !== want.diff)
            flag_mismatch("difference", longint'(want.diff), longint'(got.diff));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows run under the first idling mix
    for (int i = 0; i < 25; i++) send_request(dir_tbl[i]);

    // Random phases: sender-light, then receiver-light, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle = 33; dst_idle = 57; end
        1: begin src_idle = 57; dst_idle = 33; end
        default: begin src_idle = 0; dst_idle = 0; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_request(random_row());
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then give stray results a chance to show up
    while (expected_time_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* time_of_day_clock_hms.f */
rtl/core/tod_pkg.sv
rtl/core/tod_skid.sv
rtl/core/tod_front.sv
rtl/core/tod_mod_day.sv
rtl/core/tod_core.sv
rtl/core/time_of_day_clock_hms.sv
tb/testbench.sv
